@@ rtl/dgrw_pkg.sv @@
// ----------------------------------------------------------------------------
// dgrw_pkg: shared definitions for the DDA grid ray walk unit
// Widths, fixed-point constants, opcodes and the divider handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dgrw_pkg;

	// Map geometry: a square map whose side is a power of two.
	localparam int CELL_W   = 6;
	localparam int MAP_SIZE = 1 << CELL_W;
	localparam int ADDR_W   = 2 * CELL_W;
	localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;

	// Fixed-point formats.
	localparam int FRAC_BITS = 16;
	localparam int POS_W     = CELL_W + FRAC_BITS;
	localparam int DIR_W     = FRAC_BITS + 2;
	localparam int DIST_W    = 32;

	// Signed numerator of the wall distance and its magnitude.
	localparam int NUM_S_W = POS_W + 2;
	localparam int NUM_W   = POS_W + 1;

	// Default walk limit.
	localparam int MAX_STEPS_DEF = 128;

	// Opcodes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	// Divider request and response.
	typedef struct packed {
		logic               go;
		logic [NUM_W-1:0]   num;
		logic [DIR_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIST_W-1:0]  quo;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/dgrw_ram.sv @@
// ----------------------------------------------------------------------------
// dgrw_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dgrw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/dgrw_div.sv @@
// ----------------------------------------------------------------------------
// dgrw_div: restoring divider for the perpendicular wall distance
// Computes (num << FRAC_BITS) / den one quotient bit per cycle and
// saturates the quotient to the distance width.
// ----------------------------------------------------------------------------
`default_nettype none

module dgrw_div
	import dgrw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int DVD_W = NUM_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIR_W-1:0] rem_q;
	logic [DIR_W-1:0] den_q;
	logic [DVD_W-1:0] quo_q;

	logic [DIR_W:0]   trial;
	logic [DIR_W:0]   diff;
	logic             fits;

	// Trial subtraction of the shifted partial remainder.
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient datapath.
	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= {req.num, {FRAC_BITS{1'b0}}};
		end else if (run_q) begin
			rem_q <= fits ? diff[DIR_W-1:0] : trial[DIR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	// Saturate to the distance width.
	assign rsp.done = done_q;
	assign rsp.quo  = (|quo_q[DVD_W-1:DIST_W]) ? {DIST_W{1'b1}} : quo_q[DIST_W-1:0];

endmodule

`default_nettype wire

@@ rtl/dda_grid_ray_walk_unit.sv @@
// ----------------------------------------------------------------------------
// dda_grid_ray_walk_unit: DDA ray walk over a one-bit wall map
// Map writes and ray casts share one command port; one result per cast.
// ----------------------------------------------------------------------------
// After reset the unit clears its 4096-cell wall map one cell per cycle, so
// busy stays high and no command is taken until the clear is done. A map
// write gives no result. A cast is loaded, then walks one grid step at a time,
// each step a map read (ST_STEP) and a wall test (ST_CHECK) through the
// registered-read map RAM, for at most MAX_STEPS steps; a hit with a nonzero
// direction and a positive distance then goes through the bit-serial divider.
// The result appears on the result ports with done high for exactly one
// cycle and must be captured then; busy is low in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_grid_ray_walk_unit
	import dgrw_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [CELL_W-1:0] cell_x,
	input  wire logic [CELL_W-1:0] cell_y,
	input  wire logic              wall_bit,
	input  wire logic [POS_W-1:0]  pos_x,
	input  wire logic [POS_W-1:0]  pos_y,
	input  wire logic [DIR_W-1:0]  ray_dir_x,
	input  wire logic [DIR_W-1:0]  ray_dir_y,
	input  wire logic [DIST_W-1:0] side_dist_x,
	input  wire logic [DIST_W-1:0] side_dist_y,
	input  wire logic [DIST_W-1:0] delta_dist_x,
	input  wire logic [DIST_W-1:0] delta_dist_y,
	output logic                   done,
	output logic      [CELL_W-1:0] hit_x,
	output logic      [CELL_W-1:0] hit_y,
	output logic                   hit_side,
	output logic      [DIST_W-1:0] wall_distance,
	output logic                   no_hit
);

	localparam int STEP_W  = $clog2(MAX_STEPS + 1);
	localparam int STATE_W = 3;

	localparam logic [STATE_W-1:0] ST_CLEAR = 3'd0;
	localparam logic [STATE_W-1:0] ST_IDLE  = 3'd1;
	localparam logic [STATE_W-1:0] ST_STEP  = 3'd2;
	localparam logic [STATE_W-1:0] ST_CHECK = 3'd3;
	localparam logic [STATE_W-1:0] ST_DIV   = 3'd4;

	localparam logic [CELL_W-1:0]  CELL_LAST = CELL_W'(MAP_SIZE - 1);
	localparam logic [NUM_S_W-1:0] ONE_FX    = NUM_S_W'(1) << FRAC_BITS;

	// Control state.
	logic [STATE_W-1:0] state_q;
	logic [STEP_W-1:0]  steps_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	// Walk state.
	logic [CELL_W-1:0]  walk_x_q;
	logic [CELL_W-1:0]  walk_y_q;
	logic [DIST_W-1:0]  run_x_q;
	logic [DIST_W-1:0]  run_y_q;
	logic               last_side_q;
	logic [POS_W-1:0]   pos_x_q;
	logic [POS_W-1:0]   pos_y_q;
	logic [DIR_W-1:0]   dir_x_q;
	logic [DIR_W-1:0]   dir_y_q;
	logic [DIST_W-1:0]  delta_x_q;
	logic [DIST_W-1:0]  delta_y_q;

	// Result word.
	logic               res_valid_q;
	logic [CELL_W-1:0]  res_x_q;
	logic [CELL_W-1:0]  res_y_q;
	logic               res_side_q;
	logic [DIST_W-1:0]  res_dist_q;
	logic               res_nohit_q;

	// Map RAM ports.
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic               ram_rdata;

	// Command decode.
	logic               accept;
	logic               cmd_in_map;

	// Step logic.
	logic               step_y;
	logic               at_edge;
	logic [CELL_W-1:0]  nxt_x;
	logic [CELL_W-1:0]  nxt_y;
	logic [DIST_W:0]    run_sum;
	logic [DIST_W-1:0]  run_sat;
	logic               limit_hit;

	// Distance setup.
	logic [CELL_W-1:0]  d_cell;
	logic [POS_W-1:0]   d_pos;
	logic [DIR_W-1:0]   d_dir;
	logic               d_dir_neg;
	logic [NUM_S_W-1:0] d_num;
	logic [NUM_S_W-1:0] d_num_abs;
	logic [DIR_W-1:0]   d_den;
	logic               d_dir_zero;
	logic               d_trivial;

	// Finish path.
	logic               fin_en;
	logic [CELL_W-1:0]  fin_x;
	logic [CELL_W-1:0]  fin_y;
	logic               fin_side;
	logic [DIST_W-1:0]  fin_dist;
	logic               fin_nohit;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// Handshake.
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign cmd_in_map = ({1'b0, cell_x} < (CELL_W + 1)'(MAP_SIZE)) &&
	                    ({1'b0, cell_y} < (CELL_W + 1)'(MAP_SIZE));

	// Map RAM: clearing pass after reset, then single-cell writes.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {cell_x, cell_y};
		ram_wdata = wall_bit;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 1'b0;
		end else if (accept && opcode == OP_WRITE && cmd_in_map) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = (state_q == ST_STEP);
	assign ram_raddr = {nxt_x, nxt_y};

	dgrw_ram #(
		.WIDTH (1),
		.DEPTH (MAP_CELLS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Choose the axis, the next cell and the saturated side distance.
	assign step_y    = !(run_x_q <= run_y_q);
	assign limit_hit = (steps_q == STEP_W'(MAX_STEPS));

	always_comb begin
		nxt_x   = walk_x_q;
		nxt_y   = walk_y_q;
		at_edge = 1'b0;
		if (!step_y) begin
			at_edge = dir_x_q[DIR_W-1] ? (walk_x_q == '0) : (walk_x_q == CELL_LAST);
			nxt_x   = dir_x_q[DIR_W-1] ? walk_x_q - 1'b1 : walk_x_q + 1'b1;
			run_sum = {1'b0, run_x_q} + {1'b0, delta_x_q};
		end else begin
			at_edge = dir_y_q[DIR_W-1] ? (walk_y_q == '0) : (walk_y_q == CELL_LAST);
			nxt_y   = dir_y_q[DIR_W-1] ? walk_y_q - 1'b1 : walk_y_q + 1'b1;
			run_sum = {1'b0, run_y_q} + {1'b0, delta_y_q};
		end
		run_sat = run_sum[DIST_W] ? {DIST_W{1'b1}} : run_sum[DIST_W-1:0];
	end

	// Signed numerator and divisor magnitude of the wall distance.
	always_comb begin
		d_cell     = last_side_q ? walk_y_q : walk_x_q;
		d_pos      = last_side_q ? pos_y_q : pos_x_q;
		d_dir      = last_side_q ? dir_y_q : dir_x_q;
		d_dir_neg  = d_dir[DIR_W-1];
		d_num      = {2'b00, d_cell, {FRAC_BITS{1'b0}}} - {2'b00, d_pos} +
		             (d_dir_neg ? ONE_FX : '0);
		d_num_abs  = d_num[NUM_S_W-1] ? -d_num : d_num;
		d_den      = d_dir_neg ? -d_dir : d_dir;
		d_dir_zero = (d_dir == '0);
		d_trivial  = (d_num == '0) || (d_num[NUM_S_W-1] != d_dir_neg);
	end

	assign div_req.go  = (state_q == ST_CHECK) && ram_rdata && !d_dir_zero && !d_trivial;
	assign div_req.num = d_num_abs[NUM_W-1:0];
	assign div_req.den = d_den;

	dgrw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Result selection for every way a cast can end.
	always_comb begin
		fin_en    = 1'b0;
		fin_x     = walk_x_q;
		fin_y     = walk_y_q;
		fin_side  = last_side_q;
		fin_dist  = '0;
		fin_nohit = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
			end
			ST_IDLE: begin
				if (accept && opcode == OP_CAST && !cmd_in_map) begin
					fin_en   = 1'b1;
					fin_x    = cell_x;
					fin_y    = cell_y;
					fin_side = 1'b0;
				end
			end
			ST_STEP: begin
				if (limit_hit) begin
					fin_en = 1'b1;
				end else if (at_edge) begin
					fin_en   = 1'b1;
					fin_side = step_y;
				end
			end
			ST_CHECK: begin
				if (ram_rdata && (d_dir_zero || d_trivial)) begin
					fin_en    = 1'b1;
					fin_nohit = 1'b0;
					fin_dist  = d_dir_zero ? {DIST_W{1'b1}} : '0;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					fin_en    = 1'b1;
					fin_nohit = 1'b0;
					fin_dist  = div_rsp.quo;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			steps_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= fin_en;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {ADDR_W{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					steps_q <= '0;
					if (accept && opcode == OP_CAST && cmd_in_map) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (limit_hit || at_edge) begin
						state_q <= ST_IDLE;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!ram_rdata) begin
						state_q <= ST_STEP;
					end else if (d_dir_zero || d_trivial) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath: loaded on a cast, advanced on each step taken.
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_CAST) begin
			walk_x_q    <= cell_x;
			walk_y_q    <= cell_y;
			run_x_q     <= side_dist_x;
			run_y_q     <= side_dist_y;
			last_side_q <= 1'b0;
			pos_x_q     <= pos_x;
			pos_y_q     <= pos_y;
			dir_x_q     <= ray_dir_x;
			dir_y_q     <= ray_dir_y;
			delta_x_q   <= delta_dist_x;
			delta_y_q   <= delta_dist_y;
		end else if (state_q == ST_STEP && !limit_hit) begin
			last_side_q <= step_y;
			if (!at_edge) begin
				walk_x_q <= nxt_x;
				walk_y_q <= nxt_y;
				if (step_y) begin
					run_y_q <= run_sat;
				end else begin
					run_x_q <= run_sat;
				end
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (fin_en) begin
			res_x_q     <= fin_x;
			res_y_q     <= fin_y;
			res_side_q  <= fin_side;
			res_dist_q  <= fin_dist;
			res_nohit_q <= fin_nohit;
		end
	end

	assign done          = res_valid_q;
	assign hit_x         = res_x_q;
	assign hit_y         = res_y_q;
	assign hit_side      = res_side_q;
	assign wall_distance = res_dist_q;
	assign no_hit        = res_nohit_q;

	// A result word is only shown once the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE)
		else $error("result word shown while the sequencer is not idle");

	// The wall test always follows the map read issued by a step.
	a_check_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> $past(state_q) == ST_STEP)
		else $error("wall test without a preceding map read");

	// The step counter never passes the walk limit.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_W'(MAX_STEPS))
		else $error("step counter beyond the walk limit");

	// The divider only finishes while the sequencer waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the distance phase");

	// No map write overlaps a walk.
	a_no_write_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("map write during a walk");

endmodule

`default_nettype wire

@@ verif/dda_grid_ray_walk_unit_test.sv @@
// ----------------------------------------------------------------------------
// dda_grid_ray_walk_unit_test: self-checking bench for the DDA ray walk unit
// Builds wall maps with map-write words and casts rays through them. A
// behavioral model of the walk and the distance divide predicts each result,
// and every strobed result is checked field by field against it in order.
// ----------------------------------------------------------------------------

module dda_grid_ray_walk_unit_test
	import dgrw_pkg::*;
;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 4;
	localparam int WALK_LIMIT   = MAX_STEPS_DEF;
	localparam int TOTAL_WORDS  = 1150;
	localparam int DRAIN_EVERY  = 300;
	localparam int IDLE_PCT     = 19;
	localparam int QUIET_FROM   = 400;
	localparam int QUIET_TO     = 650;
	localparam int TAIL_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int MAX_PRINTS   = 40;

	localparam logic SIDE_X = 1'b0;
	localparam logic SIDE_Y = 1'b1;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam longint            DIST_CAP = 64'hFFFF_FFFF;

	// Unit step directions in signed Q1.16 and the two extremes.
	localparam logic [DIR_W-1:0] DIR_PLUS_ONE  = 18'h10000;
	localparam logic [DIR_W-1:0] DIR_MINUS_ONE = 18'h30000;
	localparam logic [DIR_W-1:0] DIR_MOST_NEG  = 18'h20000;
	localparam logic [DIR_W-1:0] DIR_MOST_POS  = 18'h1FFFF;
	localparam logic [DIR_W-1:0] DIR_ZERO      = '0;

	// One command word; a barrier entry holds the sender until all results are in.
	typedef struct packed {
		logic              barrier;
		logic              opcode;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic              wall_bit;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [DIR_W-1:0]  ray_dir_x;
		logic [DIR_W-1:0]  ray_dir_y;
		logic [DIST_W-1:0] side_dist_x;
		logic [DIST_W-1:0] side_dist_y;
		logic [DIST_W-1:0] delta_dist_x;
		logic [DIST_W-1:0] delta_dist_y;
	} command_t;

	typedef struct packed {
		logic [CELL_W-1:0] hit_x;
		logic [CELL_W-1:0] hit_y;
		logic              hit_side;
		logic [DIST_W-1:0] wall_distance;
		logic              no_hit;
	} ray_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic busy;
	logic done;
	logic [CELL_W-1:0] hit_x;
	logic [CELL_W-1:0] hit_y;
	logic              hit_side;
	logic [DIST_W-1:0] wall_distance;
	logic              no_hit;

	command_t    drive_word = '0;
	command_t    command_q[$];
	ray_result_t cast_results_q[$];
	ray_result_t want_result;
	bit          wall_shadow [MAP_SIZE][MAP_SIZE];

	logic word_taken   = 1'b0;
	bit   sender_rests;
	int   words_sent   = 0;
	int   stim_words   = 0;
	int   error_count  = 0;
	int   cycle_count  = 0;
	int   writes_seen  = 0;
	int   casts_seen   = 0;
	int   walls_hit    = 0;
	int   walks_missed = 0;

	dda_grid_ray_walk_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (drive_word.opcode),
		.cell_x       (drive_word.cell_x),
		.cell_y       (drive_word.cell_y),
		.wall_bit     (drive_word.wall_bit),
		.pos_x        (drive_word.pos_x),
		.pos_y        (drive_word.pos_y),
		.ray_dir_x    (drive_word.ray_dir_x),
		.ray_dir_y    (drive_word.ray_dir_y),
		.side_dist_x  (drive_word.side_dist_x),
		.side_dist_y  (drive_word.side_dist_y),
		.delta_dist_x (drive_word.delta_dist_x),
		.delta_dist_y (drive_word.delta_dist_y),
		.done         (done),
		.hit_x        (hit_x),
		.hit_y        (hit_y),
		.hit_side     (hit_side),
		.wall_distance(wall_distance),
		.no_hit       (no_hit)
	);

	// Free-running clock.
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Print one mismatch line, up to a cap, and count it.
	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS) begin
			$display("ERROR cycle %0d: %s", cycle_count, msg);
		end
	endtask

	// Running side distances saturate instead of wrapping.
	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b);
		logic [DIST_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	endfunction

	// Perpendicular distance from the player to the gridline of the hit cell.
	function automatic logic [DIST_W-1:0] wall_span(input int grid_idx,
		input logic [POS_W-1:0] pos, input longint dir);
		longint num;
		longint quo;
		num = (longint'(grid_idx) << FRAC_BITS) - longint'(pos);
		if (dir < 0) begin
			num = num + (longint'(1) << FRAC_BITS);
		end
		if (dir == 0) begin
			return DIST_MAX;
		end
		if (num == 0 || ((num < 0) != (dir < 0))) begin
			return '0;
		end
		if (num < 0) begin
			num = -num;
		end
		if (dir < 0) begin
			dir = -dir;
		end
		quo = (num << FRAC_BITS) / dir;
		return (quo > DIST_CAP) ? DIST_MAX : quo[DIST_W-1:0];
	endfunction

	// Walk the shadow map from the start cell until a wall, the map edge or the walk limit.
	function automatic ray_result_t trace_ray(input command_t c);
		ray_result_t r;
		int          wx;
		int          wy;
		int          steps;
		longint      dx;
		longint      dy;
		logic [DIST_W-1:0] sx;
		logic [DIST_W-1:0] sy;
		logic        side;
		bit          stop;
		bit          hit;
		wx    = c.cell_x;
		wy    = c.cell_y;
		dx    = $signed(c.ray_dir_x);
		dy    = $signed(c.ray_dir_y);
		sx    = c.side_dist_x;
		sy    = c.side_dist_y;
		side  = SIDE_X;
		stop  = 1'b0;
		hit   = 1'b0;
		steps = 0;
		while (!stop && steps < WALK_LIMIT) begin
			if (sx <= sy) begin
				side = SIDE_X;
				if (dx < 0 ? wx == 0 : wx == MAP_SIZE - 1) begin
					stop = 1'b1;
				end else begin
					wx = (dx < 0) ? wx - 1 : wx + 1;
					sx = sat_add(sx, c.delta_dist_x);
				end
			end else begin
				side = SIDE_Y;
				if (dy < 0 ? wy == 0 : wy == MAP_SIZE - 1) begin
					stop = 1'b1;
				end else begin
					wy = (dy < 0) ? wy - 1 : wy + 1;
					sy = sat_add(sy, c.delta_dist_y);
				end
			end
			if (!stop) begin
				steps++;
				if (wall_shadow[wx][wy]) begin
					hit  = 1'b1;
					stop = 1'b1;
				end
			end
		end
		r.hit_x    = wx[CELL_W-1:0];
		r.hit_y    = wy[CELL_W-1:0];
		r.hit_side = side;
		r.no_hit   = !hit;
		if (!hit) begin
			r.wall_distance = '0;
		end else if (side == SIDE_X) begin
			r.wall_distance = wall_span(wx, c.pos_x, dx);
		end else begin
			r.wall_distance = wall_span(wy, c.pos_y, dy);
		end
		return r;
	endfunction

	// Gridline spacing as a game engine would set it: 1 / |dir|, saturated.
	function automatic logic [DIST_W-1:0] grid_spacing(input logic [DIR_W-1:0] dir);
		longint mag;
		longint quo;
		mag = $signed(dir);
		if (mag < 0) begin
			mag = -mag;
		end
		if (mag == 0) begin
			return DIST_MAX;
		end
		quo = (longint'(1) << 32) / mag;
		return (quo > DIST_CAP) ? DIST_MAX : quo[DIST_W-1:0];
	endfunction

	// Distance from the player to the first gridline in the step direction.
	function automatic logic [DIST_W-1:0] first_crossing(input logic [FRAC_BITS-1:0] frac,
		input logic [DIR_W-1:0] dir, input logic [DIST_W-1:0] delta);
		longint part;
		longint span;
		if ($signed(dir) < 0) begin
			part = frac;
		end else begin
			part = (longint'(1) << FRAC_BITS) - frac;
		end
		span = (part * delta) >> FRAC_BITS;
		return (span > DIST_CAP) ? DIST_MAX : span[DIST_W-1:0];
	endfunction

	task automatic push_word(input command_t c);
		command_q.push_back(c);
		stim_words++;
	endtask

	task automatic push_write(input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
		input logic wall);
		command_t c;
		c          = '0;
		c.opcode   = OP_WRITE;
		c.cell_x   = cx;
		c.cell_y   = cy;
		c.wall_bit = wall;
		c.pos_x    = POS_W'($urandom);
		c.ray_dir_y = DIR_W'($urandom);
		push_word(c);
	endtask

	task automatic push_cast(input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
		input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
		input logic [DIR_W-1:0] dx, input logic [DIR_W-1:0] dy,
		input logic [DIST_W-1:0] sx, input logic [DIST_W-1:0] sy,
		input logic [DIST_W-1:0] ddx, input logic [DIST_W-1:0] ddy);
		command_t c;
		c              = '0;
		c.opcode       = OP_CAST;
		c.cell_x       = cx;
		c.cell_y       = cy;
		c.pos_x        = px;
		c.pos_y        = py;
		c.ray_dir_x    = dx;
		c.ray_dir_y    = dy;
		c.side_dist_x  = sx;
		c.side_dist_y  = sy;
		c.delta_dist_x = ddx;
		c.delta_dist_y = ddy;
		push_word(c);
	endtask

	task automatic push_barrier();
		command_t c;
		c         = '0;
		c.barrier = 1'b1;
		command_q.push_back(c);
	endtask

	// A cast either set up consistently from a position and direction, or all noise.
	function automatic command_t random_cast(input bit noisy);
		command_t c;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		c          = '0;
		c.opcode   = OP_CAST;
		c.cell_x   = CELL_W'($urandom);
		c.cell_y   = CELL_W'($urandom);
		c.wall_bit = 1'($urandom);
		if (noisy) begin
			c.pos_x        = POS_W'($urandom);
			c.pos_y        = POS_W'($urandom);
			c.ray_dir_x    = DIR_W'($urandom);
			c.ray_dir_y    = DIR_W'($urandom);
			c.side_dist_x  = $urandom;
			c.side_dist_y  = $urandom;
			c.delta_dist_x = $urandom;
			c.delta_dist_y = $urandom;
		end else begin
			fx             = FRAC_BITS'($urandom);
			fy             = FRAC_BITS'($urandom);
			c.pos_x        = {c.cell_x, fx};
			c.pos_y        = {c.cell_y, fy};
			c.ray_dir_x    = ($urandom_range(0, 19) == 0) ? DIR_ZERO : DIR_W'($urandom);
			c.ray_dir_y    = ($urandom_range(0, 19) == 0) ? DIR_ZERO : DIR_W'($urandom);
			c.delta_dist_x = grid_spacing(c.ray_dir_x);
			c.delta_dist_y = grid_spacing(c.ray_dir_y);
			c.side_dist_x  = first_crossing(fx, c.ray_dir_x, c.delta_dist_x);
			c.side_dist_y  = first_crossing(fy, c.ray_dir_y, c.delta_dist_y);
		end
		return c;
	endfunction

	// Sender: a new word goes out at the falling edge once the last one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || word_taken) begin
			sender_rests = (words_sent < QUIET_FROM || words_sent >= QUIET_TO) &&
				($urandom_range(0, 99) < IDLE_PCT);
			if (command_q.size() == 0) begin
				start <= 1'b0;
			end else if (command_q[0].barrier) begin
				// Hold off until every cast in flight has reported.
				start <= 1'b0;
				if (cast_results_q.size() == 0) begin
					void'(command_q.pop_front());
				end
			end else if (sender_rests) begin
				start <= 1'b0;
			end else begin
				drive_word <= command_q.pop_front();
				start      <= 1'b1;
				words_sent++;
			end
		end
	end

	// Receiver: check each strobed result, then record the word taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (cast_results_q.size() == 0) begin
					report_error($sformatf("result at (%0d,%0d) with no cast pending",
						hit_x, hit_y));
				end else begin
					want_result = cast_results_q.pop_front();
					if (hit_x !== want_result.hit_x) begin
						report_error($sformatf("hit_x %0d, expected %0d",
							hit_x, want_result.hit_x));
					end
					if (hit_y !== want_result.hit_y) begin
						report_error($sformatf("hit_y %0d, expected %0d",
							hit_y, want_result.hit_y));
					end
					if (hit_side !== want_result.hit_side) begin
						report_error($sformatf("hit_side %0d, expected %0d",
							hit_side, want_result.hit_side));
					end
					if (wall_distance !== want_result.wall_distance) begin
						report_error($sformatf("wall_distance %h, expected %h",
							wall_distance, want_result.wall_distance));
					end
					if (no_hit !== want_result.no_hit) begin
						report_error($sformatf("no_hit %0d, expected %0d",
							no_hit, want_result.no_hit));
					end
					if (want_result.no_hit) begin
						walks_missed++;
					end else begin
						walls_hit++;
					end
				end
			end
			if (start && !busy) begin
				if (drive_word.opcode == OP_WRITE) begin
					wall_shadow[drive_word.cell_x][drive_word.cell_y] = drive_word.wall_bit;
					writes_seen++;
				end else begin
					cast_results_q.push_back(trace_ray(drive_word));
					casts_seen++;
				end
			end
		end
		word_taken <= arst_n && start && !busy;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dda_grid_ray_walk_unit_test: errors");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int               pick;
		int               run_len;
		int               next_drain;
		bit               along_x;
		logic [CELL_W-1:0] rx;
		logic [CELL_W-1:0] ry;

		// Walls used by the directed casts, plus the two corners.
		push_write(10, 20, 1'b1);
		push_write(10, 19, 1'b1);
		push_write(0, 0, 1'b1);
		push_write(63, 63, 1'b1);

		// Plain hits along +x, -x and -y.
		push_cast(5, 20, 22'h58000, 22'h148000, DIR_PLUS_ONE, DIR_ZERO,
			32'h8000, DIST_MAX, 32'h10000, DIST_MAX);
		push_cast(15, 20, 22'hF8000, 22'h148000, DIR_MINUS_ONE, DIR_ZERO,
			32'h8000, DIST_MAX, 32'h10000, DIST_MAX);
		push_cast(10, 25, 22'hA8000, 22'h198000, DIR_ZERO, DIR_MINUS_ONE,
			DIST_MAX, 32'h8000, DIST_MAX, 32'h10000);
		// Hit with a zero direction on the crossed axis: distance saturates.
		push_cast(5, 20, 22'h58000, 22'h148000, DIR_ZERO, DIR_PLUS_ONE,
			32'h0, 32'h10000, 32'h0, 32'h10000);
		// Player already past the wall: the quotient would be negative.
		push_cast(5, 20, 22'hC0000, 22'h148000, DIR_PLUS_ONE, DIR_ZERO,
			32'h8000, DIST_MAX, 32'h10000, DIST_MAX);
		// Player exactly on the gridline: zero numerator.
		push_cast(5, 20, 22'hA0000, 22'h148000, DIR_PLUS_ONE, DIR_ZERO,
			32'h8000, DIST_MAX, 32'h10000, DIST_MAX);
		// Tiny direction: the quotient overflows and saturates.
		push_cast(5, 20, 22'h50000, 22'h148000, 18'h00001, DIR_ZERO,
			32'h8000, DIST_MAX, 32'h10000, DIST_MAX);
		// Equal side distances step along x first.
		push_cast(9, 19, 22'h98000, 22'h138000, DIR_PLUS_ONE, DIR_PLUS_ONE,
			32'h8000, 32'h8000, 32'h10000, 32'h10000);
		// Each map edge refuses the very first step.
		push_cast(0, 5, 22'h08000, 22'h58000, DIR_MINUS_ONE, DIR_PLUS_ONE,
			32'h0, DIST_MAX, 32'h10000, 32'h10000);
		push_cast(63, 5, 22'h3F8000, 22'h58000, DIR_PLUS_ONE, DIR_PLUS_ONE,
			32'h0, DIST_MAX, 32'h10000, 32'h10000);
		push_cast(5, 0, 22'h58000, 22'h08000, DIR_PLUS_ONE, DIR_MINUS_ONE,
			DIST_MAX, 32'h0, 32'h10000, 32'h10000);
		push_cast(5, 63, 22'h58000, 22'h3F8000, DIR_PLUS_ONE, DIR_PLUS_ONE,
			DIST_MAX, 32'h0, 32'h10000, 32'h10000);
		// Starting on a wall cell: the start cell is not tested.
		push_cast(10, 20, 22'hA8000, 22'h148000, DIR_PLUS_ONE, DIR_ZERO,
			32'h8000, DIST_MAX, 32'h10000, DIST_MAX);
		// Side distances saturate, then tie, then the walk runs off the map.
		push_cast(1, 1, 22'h18000, 22'h18000, DIR_MINUS_ONE, DIR_MINUS_ONE,
			32'hFFFF_FFF0, DIST_MAX, DIST_MAX, DIST_MAX);
		// Extreme directions and positions.
		push_cast(40, 3, 22'h3FFFFF, 22'h000000, DIR_MOST_NEG, DIR_MOST_POS,
			32'h0, 32'h1, 32'h1, 32'h1);
		push_cast(40, 60, 22'h000000, 22'h3FFFFF, DIR_MOST_POS, DIR_MOST_NEG,
			32'h1, 32'h0, 32'h1, 32'h1);
		// Clear a wall and walk through where it stood.
		push_write(10, 20, 1'b0);
		push_cast(5, 20, 22'h58000, 22'h148000, DIR_PLUS_ONE, DIR_ZERO,
			32'h8000, DIST_MAX, 32'h10000, DIST_MAX);
		push_barrier();

		// Random part: scattered writes, wall runs and casts through the map.
		next_drain = stim_words + DRAIN_EVERY;
		while (stim_words < TOTAL_WORDS) begin
			if (stim_words >= next_drain) begin
				push_barrier();
				next_drain = next_drain + DRAIN_EVERY;
			end
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				repeat ($urandom_range(1, 4)) begin
					push_write(CELL_W'($urandom), CELL_W'($urandom),
						$urandom_range(0, 99) < 80);
				end
			end else if (pick < 42) begin
				along_x = 1'($urandom_range(0, 1));
				rx      = CELL_W'($urandom);
				ry      = CELL_W'($urandom);
				run_len = $urandom_range(3, 10);
				for (int k = 0; k < run_len; k++) begin
					push_write(along_x ? CELL_W'(rx + k) : rx,
						along_x ? ry : CELL_W'(ry + k), 1'b1);
				end
			end else if (pick < 78) begin
				push_word(random_cast(1'b0));
			end else begin
				push_word(random_cast(1'b1));
			end
		end

		// Reset, released at a falling edge.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every word to be taken and every result to come back.
		while (command_q.size() != 0 || start) @(posedge clk);
		while (cast_results_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d map writes and %0d ray casts.", writes_seen, casts_seen);
		$display("%0d casts reached a wall and %0d ended without one.",
			walls_hit, walks_missed);
		if (error_count == 0) begin
			$display("dda_grid_ray_walk_unit_test: clean");
		end else begin
			$display("dda_grid_ray_walk_unit_test: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/dgrw_pkg.sv
rtl/dgrw_ram.sv
rtl/dgrw_div.sv
rtl/dda_grid_ray_walk_unit.sv
verif/dda_grid_ray_walk_unit_test.sv
